### rtl/lskvt_pkg.sv
package lskvt_pkg;

   localparam logic [1:0] OP_FIND   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_UPDATE = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_BADPOS    = 2'd3;

   localparam logic [1:0] CSR_NODE_IS_ROOT      = 2'd0;
   localparam logic [1:0] CSR_MIN_CELLS_NONROOT = 2'd1;
   localparam logic [1:0] CSR_MIN_CELLS_ROOT    = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] search_key;
      logic [4:0]  position;
      logic [63:0] row_payload;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] found_index;
      logic       key_found;
      logic [4:0] cell_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       find_init;
      logic       find_done;
      logic       find_read;
      logic       find_step;
      logic       shift_up_init;
      logic       shift_dn_init;
      logic       shift_up;
      logic       shift_dn;
      logic       write_new;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       ins_bad;
      logic       pos_ge;
      logic       underflow;
      logic       lo_eq_hi;
      logic       key_eq;
      logic       up_done;
      logic       dn_done;
      logic       rsp_free;
   } stat_type;

endpackage

### rtl/lskvt_datapath.sv
module lskvt_datapath #(
   parameter int NODE_CELLS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  lskvt_pkg::cmd_type cmd,
   output lskvt_pkg::stat_type stat,
   input  lskvt_pkg::req_type req_payload,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_wdata,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output lskvt_pkg::rsp_type rsp_payload
);

   localparam int AW = (NODE_CELLS > 1) ? $clog2(NODE_CELLS) : 1;
   localparam int CW = $clog2(NODE_CELLS + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   logic [31:0] key_mem [NODE_CELLS];
   logic [63:0] pay_mem [NODE_CELLS];

   logic        is_root_ff;
   logic [4:0]  min_nonroot_ff;
   logic [4:0]  min_root_ff;

   logic [1:0]  op_ff;
   logic [31:0] key_ff;
   logic [4:0]  pos_ff;
   logic [63:0] pay_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic [4:0]    fidx_ff, fidx_in;
   logic          hit_ff, hit_in;

   logic [31:0]   rd_key_ff;
   logic [63:0]   rd_pay_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_key;
   logic [63:0]   wr_pay;

   logic          rsp_valid_ff, rsp_valid_in;
   lskvt_pkg::rsp_type rsp_ff;

   logic [CW:0]   lo_hi_sum;
   logic [4:0]    minimum;
   logic          up_more;
   logic          dn_more;

   always_comb begin
      lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      minimum   = is_root_ff ? min_root_ff : min_nonroot_ff;
      up_more   = XW'(ptr_ff) > XW'(pos_ff);
      dn_more   = ({1'b0, ptr_ff} + (CW+1)'(1)) < {1'b0, count_ff};
   end

   always_comb begin
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      mid_in       = mid_ff;
      fidx_in      = fidx_ff;
      hit_in       = hit_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_ff;

      if (cmd.load) begin
         fidx_in = 5'd0;
         hit_in  = 1'b0;
      end
      if (cmd.find_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.find_done) begin
         fidx_in = 5'(lo_ff);
      end
      if (cmd.find_read) begin
         mid_in  = AW'(lo_hi_sum >> 1);
         rd_en   = 1'b1;
         rd_addr = AW'(lo_hi_sum >> 1);
      end
      if (cmd.find_step) begin
         if (key_ff == rd_key_ff) begin
            fidx_in = 5'(mid_ff);
            hit_in  = 1'b1;
         end else if (key_ff < rd_key_ff) begin
            hi_in = CW'(mid_ff);
         end else begin
            lo_in = CW'(mid_ff) + CW'(1);
         end
      end
      if (cmd.shift_up_init) begin
         ptr_in  = count_ff;
         pend_in = 1'b0;
      end
      if (cmd.shift_dn_init) begin
         ptr_in  = CW'(pos_ff);
         pend_in = 1'b0;
      end
      // one cell moves per cycle: read the neighbour now, write it next cycle
      if (cmd.shift_up) begin
         if (up_more) begin
            rd_en        = 1'b1;
            rd_addr      = AW'(ptr_ff - CW'(1));
            pend_addr_in = AW'(ptr_ff);
            pend_in      = 1'b1;
            ptr_in       = ptr_ff - CW'(1);
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.shift_dn) begin
         if (dn_more) begin
            rd_en        = 1'b1;
            rd_addr      = AW'(ptr_ff + CW'(1));
            pend_addr_in = AW'(ptr_ff);
            pend_in      = 1'b1;
            ptr_in       = ptr_ff + CW'(1);
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      wr_en   = cmd.write_new | ((cmd.shift_up | cmd.shift_dn) & pend_ff);
      wr_addr = cmd.write_new ? AW'(pos_ff) : pend_addr_ff;
      wr_key  = cmd.write_new ? key_ff : rd_key_ff;
      wr_pay  = cmd.write_new ? pay_ff : rd_pay_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_pay;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_pay_ff <= pay_mem[rd_addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_root_ff     <= 1'b0;
         min_nonroot_ff <= 5'd0;
         min_root_ff    <= 5'd0;
         count_ff       <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               lskvt_pkg::CSR_NODE_IS_ROOT:      is_root_ff     <= csr_wdata[0];
               lskvt_pkg::CSR_MIN_CELLS_NONROOT: min_nonroot_ff <= csr_wdata;
               lskvt_pkg::CSR_MIN_CELLS_ROOT:    min_root_ff    <= csr_wdata;
               default: ;
            endcase
         end
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_payload.op;
         key_ff <= req_payload.search_key;
         pos_ff <= req_payload.position;
         pay_ff <= req_payload.row_payload;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      mid_ff       <= mid_in;
      fidx_ff      <= fidx_in;
      hit_ff       <= hit_in;
      if (cmd.rsp_load) begin
         rsp_ff.status      <= cmd.rsp_status;
         rsp_ff.found_index <= fidx_ff;
         rsp_ff.key_found   <= hit_ff;
         rsp_ff.cell_count  <= 5'(count_ff);
      end
   end

   always_comb begin
      stat.op        = op_ff;
      stat.full      = count_ff >= CW'(NODE_CELLS);
      stat.ins_bad   = XW'(pos_ff) > XW'(count_ff);
      stat.pos_ge    = XW'(pos_ff) >= XW'(count_ff);
      stat.underflow = XW'(count_ff) < XW'(minimum);
      stat.lo_eq_hi  = lo_ff == hi_ff;
      stat.key_eq    = key_ff == rd_key_ff;
      stat.up_done   = !up_more && !pend_ff;
      stat.dn_done   = !dn_more && !pend_ff;
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/lskvt_ctrl.sv
module lskvt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lskvt_pkg::stat_type stat,
   output lskvt_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_FIND_CHK = 3'd2;
   localparam logic [2:0] S_FIND_CMP = 3'd3;
   localparam logic [2:0] S_SHIFT_UP = 3'd4;
   localparam logic [2:0] S_SHIFT_DN = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.rsp_status = status_ff;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               status_in = lskvt_pkg::ST_OK;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               lskvt_pkg::OP_FIND: begin
                  cmd.find_init = 1'b1;
                  state_in      = S_FIND_CHK;
               end
               lskvt_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     status_in = lskvt_pkg::ST_FULL;
                     state_in  = S_RESP;
                  end else if (stat.ins_bad) begin
                     status_in = lskvt_pkg::ST_BADPOS;
                     state_in  = S_RESP;
                  end else begin
                     cmd.shift_up_init = 1'b1;
                     state_in          = S_SHIFT_UP;
                  end
               end
               lskvt_pkg::OP_DELETE: begin
                  if (stat.underflow) begin
                     status_in = lskvt_pkg::ST_UNDERFLOW;
                     state_in  = S_RESP;
                  end else if (stat.pos_ge) begin
                     status_in = lskvt_pkg::ST_BADPOS;
                     state_in  = S_RESP;
                  end else begin
                     cmd.shift_dn_init = 1'b1;
                     state_in          = S_SHIFT_DN;
                  end
               end
               lskvt_pkg::OP_UPDATE: begin
                  if (stat.pos_ge) begin
                     status_in = lskvt_pkg::ST_BADPOS;
                  end else begin
                     cmd.write_new = 1'b1;
                  end
                  state_in = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_FIND_CHK: begin
            if (stat.lo_eq_hi) begin
               cmd.find_done = 1'b1;
               state_in      = S_RESP;
            end else begin
               cmd.find_read = 1'b1;
               state_in      = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            cmd.find_step = 1'b1;
            state_in      = stat.key_eq ? S_RESP : S_FIND_CHK;
         end
         S_SHIFT_UP: begin
            cmd.shift_up = 1'b1;
            if (stat.up_done) begin
               cmd.write_new = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_SHIFT_DN: begin
            cmd.shift_dn = 1'b1;
            if (stat.dn_done) begin
               cmd.count_dec = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= lskvt_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

### rtl/leaf_sorted_key_value_table.sv
// Leaf node of a sorted key/payload table: find, insert, delete and update, one
// request at a time, each giving one response. A find runs a binary search over
// the cells. An insert moves the cells at and above the position up by one and
// then writes the new cell, and a delete moves the cells above the position down
// by one; the single read port of the cell memory moves one cell per cycle while
// shifting. A finished response waits in an output register, so the next request
// is taken while it is still pending; the next response then waits until that
// one is taken. Cells are not cleared at reset and only cells below the count
// are ever read.
module leaf_sorted_key_value_table #(
   parameter int NODE_CELLS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lskvt_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lskvt_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_wdata
);

   lskvt_pkg::cmd_type  cmd;
   lskvt_pkg::stat_type stat;

   lskvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lskvt_datapath #(
      .NODE_CELLS (NODE_CELLS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
